@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CAPACITY    = 64;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_CLEAR      = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] push_value;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_OUT_W-1:0]   count;
    } t_out_rsp;

    // slot memory strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // request outcome known at accept time, waits for the slot read
    typedef struct packed {
        logic                   pop_ok;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count;
    } t_rsp_info;

endpackage

@@ rtl/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values in a circular buffer.
// ----------------------------------------------------------------------------
//  channel   valid        stall        payload
//  request   i_in_valid   o_in_stall   i_in_req  (kind, push_value)
//  response  o_out_valid  i_out_stall  o_out_rsp (pop_value, status, count)
//
//  One request per cycle unless o_in_stall is high.
//  Pointers update at accept; the slot access is issued the same cycle and
//  the single-port slot memory returns pop data in the next cycle.
//  A response waits in the output register while the next request is taken;
//  the request side stalls only when both the read stage and output are full.
//  Synchronous active-low reset empties the queue; slot contents are kept.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int CAPACITY = deq_pkg::CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  deq_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_out_rsp o_out_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                        accept;
    logic                        advance;
    deq_pkg::t_mem_ctl           mem_ctl;
    logic [IDX_W-1:0]            mem_addr;
    logic [deq_pkg::DATA_W-1:0]  mem_rdata;
    deq_pkg::t_rsp_info          info;

    logic                        r_s1_vld;
    deq_pkg::t_rsp_info          r_s1_info;
    logic                        r_out_vld;
    deq_pkg::t_out_rsp           r_out;

    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    deq_ptr_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_kind     (i_in_req.kind),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_info     (info)
    );

    deq_slot_ram #(
        .DEPTH(CAPACITY),
        .WIDTH(deq_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (i_in_req.push_value),
        .o_rdata (mem_rdata)
    );

    // read stage: waits for slot data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_vld) begin
            r_out.pop_value <= r_s1_info.pop_ok ? mem_rdata : '0;
            r_out.status    <= r_s1_info.status;
            r_out.count     <= r_s1_info.count;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

endmodule

@@ rtl/deq_slot_ram.sv @@
// ----------------------------------------------------------------------------
// deq_slot_ram
// Single-port slot memory with registered read data.
// ----------------------------------------------------------------------------
module deq_slot_ram #(
    parameter int DEPTH = deq_pkg::CAPACITY,
    parameter int WIDTH = deq_pkg::DATA_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  deq_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/deq_ptr_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ptr_ctrl
// Front pointer and element count; decodes a request into at most one slot access.
// ----------------------------------------------------------------------------
module deq_ptr_ctrl #(
    parameter int CAPACITY = deq_pkg::CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [deq_pkg::KIND_W-1:0]       i_kind,
    output deq_pkg::t_mem_ctl                o_mem_ctl,
    output logic [IDX_W-1:0]                 o_mem_addr,
    output deq_pkg::t_rsp_info               o_info
);

    localparam int SUM_W = IDX_W + 1;

    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;

    logic             full, empty;
    logic [IDX_W-1:0] front_dec, front_inc;
    logic [SUM_W-1:0] back_sum, last_sum;
    logic [SUM_W-1:0] back_wrap, last_wrap;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    assign front_dec = (r_front == '0) ? IDX_W'(CAPACITY - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IDX_W'(CAPACITY - 1)) ? '0 : r_front + 1'b1;

    // front + count stays below twice the capacity: one compare and subtract
    assign back_sum  = {1'b0, r_front} + SUM_W'(r_count);
    assign last_sum  = back_sum - 1'b1;
    assign back_wrap = (back_sum >= SUM_W'(CAPACITY)) ? back_sum - SUM_W'(CAPACITY)
                                                      : back_sum;
    assign last_wrap = (last_sum >= SUM_W'(CAPACITY)) ? last_sum - SUM_W'(CAPACITY)
                                                      : last_sum;

    always_comb begin
        n_front          = r_front;
        n_count          = r_count;
        o_mem_ctl        = '0;
        o_mem_addr       = r_front;
        o_info.pop_ok    = 1'b0;
        o_info.status    = deq_pkg::ST_OK;
        case (i_kind)
            deq_pkg::KIND_PUSH_FRONT: begin
                if (full) begin
                    o_info.status = deq_pkg::ST_FULL;
                end else begin
                    n_front         = front_dec;
                    n_count         = r_count + 1'b1;
                    o_mem_ctl.wr_en = i_accept;
                    o_mem_addr      = front_dec;
                end
            end
            deq_pkg::KIND_PUSH_BACK: begin
                if (full) begin
                    o_info.status = deq_pkg::ST_FULL;
                end else begin
                    n_count         = r_count + 1'b1;
                    o_mem_ctl.wr_en = i_accept;
                    o_mem_addr      = back_wrap[IDX_W-1:0];
                end
            end
            deq_pkg::KIND_POP_FRONT: begin
                if (empty) begin
                    o_info.status = deq_pkg::ST_EMPTY;
                end else begin
                    n_front         = front_inc;
                    n_count         = r_count - 1'b1;
                    o_mem_ctl.rd_en = i_accept;
                    o_info.pop_ok   = 1'b1;
                end
            end
            deq_pkg::KIND_POP_BACK: begin
                if (empty) begin
                    o_info.status = deq_pkg::ST_EMPTY;
                end else begin
                    n_count         = r_count - 1'b1;
                    o_mem_ctl.rd_en = i_accept;
                    o_mem_addr      = last_wrap[IDX_W-1:0];
                    o_info.pop_ok   = 1'b1;
                end
            end
            deq_pkg::KIND_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
        // count is reported modulo the 7-bit field
        o_info.count = deq_pkg::COUNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int CAPACITY = deq_pkg::CAPACITY
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input deq_pkg::t_in_req  i_in_req,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input deq_pkg::t_out_rsp o_out_rsp
);

    localparam logic [deq_pkg::COUNT_OUT_W-1:0] CAP_CNT =
        deq_pkg::COUNT_OUT_W'(CAPACITY);

    // a stalled request holds
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_req))
        else $error("request changed while stalled");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("response changed while stalled");

    // refused push only when the queue holds its full capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.status == deq_pkg::ST_FULL |->
            o_out_rsp.count == CAP_CNT && o_out_rsp.pop_value == '0)
        else $error("full status with wrong count or value");

    // failed pop leaves an empty queue and no data
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_rsp.status == deq_pkg::ST_EMPTY |->
            o_out_rsp.count == '0 && o_out_rsp.pop_value == '0)
        else $error("empty status with wrong count or value");

    // count never exceeds the capacity where the field is wide enough
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (CAPACITY >= (1 << deq_pkg::COUNT_OUT_W)) || o_out_rsp.count <= CAP_CNT)
        else $error("count above capacity");

endmodule

bind double_ended_queue_unit deq_checker #(
    .CAPACITY(CAPACITY)
) u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);

@@ bench/tb_double_ended_queue_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Drives directed and random request streams into the deque unit with random
// gaps and response back-pressure. Each response is compared against a
// behavioral circular-buffer predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;

    localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_C = 3'd7;
    localparam int TOTAL_ITEMS = 1900;
    localparam int MAX_IDLE    = 11;
    localparam int MAX_REPORTS = 10;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} t_mode;

    class deque_scoreboard;
        logic [deq_pkg::DATA_W-1:0] slot_mem [deq_pkg::CAPACITY];
        int unsigned head_idx = 0;
        int unsigned fill = 0;
        deq_pkg::t_out_rsp expected_q [$];
        int unsigned mismatches = 0;
        int unsigned checked = 0;
        int unsigned requests = 0;
        int unsigned refused_full = 0;
        int unsigned empty_pops = 0;
        int unsigned clears = 0;

        // advance the predicted queue and queue up the expected response
        function void note_request(deq_pkg::t_in_req req);
            deq_pkg::t_out_rsp rsp;
            rsp = '0;
            requests++;
            case (req.kind)
                deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
                    if (fill >= deq_pkg::CAPACITY) begin
                        rsp.status = deq_pkg::ST_FULL;
                        refused_full++;
                    end else if (req.kind == deq_pkg::KIND_PUSH_FRONT) begin
                        head_idx = (head_idx + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
                        slot_mem[head_idx] = req.push_value;
                        fill++;
                    end else begin
                        slot_mem[(head_idx + fill) % deq_pkg::CAPACITY] = req.push_value;
                        fill++;
                    end
                end
                deq_pkg::KIND_POP_FRONT: begin
                    if (fill == 0) begin
                        rsp.status = deq_pkg::ST_EMPTY;
                        empty_pops++;
                    end else begin
                        rsp.pop_value = slot_mem[head_idx];
                        head_idx = (head_idx + 1) % deq_pkg::CAPACITY;
                        fill--;
                    end
                end
                deq_pkg::KIND_POP_BACK: begin
                    if (fill == 0) begin
                        rsp.status = deq_pkg::ST_EMPTY;
                        empty_pops++;
                    end else begin
                        rsp.pop_value = slot_mem[(head_idx + fill - 1) % deq_pkg::CAPACITY];
                        fill--;
                    end
                end
                deq_pkg::KIND_CLEAR: begin
                    head_idx = 0;
                    fill = 0;
                    clears++;
                end
                default: ;
            endcase
            rsp.count = deq_pkg::COUNT_OUT_W'(fill);
            expected_q.push_back(rsp);
        endfunction

        function void check_response(deq_pkg::t_out_rsp got);
            deq_pkg::t_out_rsp want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: response with none outstanding: %0d status %0d count %0d",
                             $time, got.pop_value, got.status, got.count);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.pop_value !== want.pop_value || got.status !== want.status ||
                    got.count !== want.count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: response %0d: expected pop_value %0d status %0d count %0d",
                             $time, checked, want.pop_value, want.status, want.count);
                    $display("%0t: response %0d: got      pop_value %0d status %0d count %0d",
                             $time, checked, got.pop_value, got.status, got.count);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    deq_pkg::t_in_req  i_in_req = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    deq_pkg::t_out_rsp o_out_rsp;

    deque_scoreboard board;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int unsigned stall_left = 0;

    double_ended_queue_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // response side: hold stall for the drawn number of cycles after each take
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_response(o_out_rsp);
            stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    function automatic deq_pkg::t_in_req make_req(logic [deq_pkg::KIND_W-1:0] kind,
                                                  logic [deq_pkg::DATA_W-1:0] value);
        deq_pkg::t_in_req req;
        req.kind = kind;
        req.push_value = value;
        return req;
    endfunction

    function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return {1'b1, {(deq_pkg::DATA_W-1){1'b0}}};
            1: return {1'b0, {(deq_pkg::DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic deq_pkg::t_in_req choose_request(t_mode mode);
        deq_pkg::t_in_req req;
        int roll;
        int push_pct;
        bit at_front;
        roll = $urandom_range(0, 99);
        at_front = 1'($urandom_range(0, 1));
        req.push_value = pick_value();
        case (mode)
            MODE_FILL:  push_pct = 90;
            MODE_DRAIN: push_pct = 10;
            default:    push_pct = 49;
        endcase
        if (mode == MODE_NOISE)
            req.kind = deq_pkg::KIND_W'($urandom_range(0, 7));
        else if (mode == MODE_MIXED && roll >= 98)
            req.kind = deq_pkg::KIND_CLEAR;
        else if (roll < push_pct)
            req.kind = at_front ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK;
        else
            req.kind = at_front ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_BACK;
        return req;
    endfunction

    // present one request after a random gap and hold it until taken
    task automatic send_request(deq_pkg::t_in_req req);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        int phase_no;
        int plen;
        t_mode mode;

        board = new;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pops, extreme values, both ends, spare codes, clear
        send_request(make_req(deq_pkg::KIND_POP_FRONT, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_POP_BACK, 32'hffff_ffff));
        send_request(make_req(deq_pkg::KIND_PUSH_FRONT, 32'h8000_0000));
        send_request(make_req(deq_pkg::KIND_PUSH_BACK, 32'h7fff_ffff));
        send_request(make_req(deq_pkg::KIND_PUSH_FRONT, 32'hffff_ffff));
        send_request(make_req(deq_pkg::KIND_PUSH_BACK, 32'h0000_0000));
        send_request(make_req(KIND_SPARE_A, 32'h1234_5678));
        send_request(make_req(KIND_SPARE_B, 32'hdead_beef));
        send_request(make_req(KIND_SPARE_C, 32'h0000_0001));
        send_request(make_req(deq_pkg::KIND_POP_FRONT, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_POP_BACK, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_POP_FRONT, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_POP_BACK, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_POP_FRONT, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_PUSH_BACK, 32'h5555_5555));
        send_request(make_req(deq_pkg::KIND_PUSH_FRONT, 32'haaaa_aaaa));
        send_request(make_req(deq_pkg::KIND_CLEAR, 32'hffff_ffff));
        send_request(make_req(deq_pkg::KIND_POP_BACK, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_CLEAR, 32'h0000_0000));
        send_request(make_req(deq_pkg::KIND_PUSH_BACK, 32'h0000_0001));
        send_request(make_req(deq_pkg::KIND_POP_FRONT, 32'h0000_0000));

        // random phases; the first two mostly push toward full, then mostly pop toward empty
        phase_no = 0;
        while (board.requests < TOTAL_ITEMS) begin
            if (phase_no == 0)
                mode = MODE_FILL;
            else if (phase_no == 1)
                mode = MODE_DRAIN;
            else
                mode = t_mode'($urandom_range(0, 3));
            plen = (phase_no < 2) ? 80 : $urandom_range(20, 120);
            tx_quiet = ($urandom_range(0, 2) == 0);
            rx_quiet = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < plen && board.requests < TOTAL_ITEMS; n++) begin
                send_request(choose_request(mode));
            end
            if (phase_no == 0 || $urandom_range(0, 3) == 0)
                wait_for_drain();
            phase_no++;
        end

        wait_for_drain();
        repeat (8) @(posedge i_clk);

        $display("%0d requests sent, %0d responses checked", board.requests, board.checked);
        $display("%0d pushes refused on full, %0d pops on empty, %0d clears",
                 board.refused_full, board.empty_pops, board.clears);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d responses missing", board.mismatches, board.pending());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d responses still outstanding", board.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/deq_pkg.sv
rtl/deq_slot_ram.sv
rtl/deq_ptr_ctrl.sv
rtl/double_ended_queue_unit.sv
rtl/deq_checker.sv
bench/tb_double_ended_queue_unit.sv
